[sv/closest_point_on_segment_unit_defines.svh]
// ----------------------------------------------------------------------------
// Closest point on segment: assertion macros
// Shared assertion wrappers for the checker.
// ----------------------------------------------------------------------------
`ifndef CLOSEST_POINT_ON_SEGMENT_UNIT_DEFINES_SVH
`define CLOSEST_POINT_ON_SEGMENT_UNIT_DEFINES_SVH

// clocked assertion, masked during reset
`define CPOS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion, also checked in reset
`define CPOS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/cpos_pkg.sv]
// ----------------------------------------------------------------------------
// Closest point on segment: package
// Widths, cell payload types and result mode codes.
// ----------------------------------------------------------------------------
package cpos_pkg;

  localparam int QW  = 32;  // quotient bits, one divider cell each
  localparam int RW  = 66;  // divisor / remainder width
  localparam int SW  = 68;  // radicand width
  localparam int RTW = 34;  // root bits, one sqrt cell each
  localparam int SRW = 37;  // sqrt remainder width

  typedef enum logic [1:0] {
    MODE_DEGEN,
    MODE_A,
    MODE_B,
    MODE_MID
  } mode_t;

  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] bx;
    logic signed [31:0] by_coord;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic               neg_x;
    logic               neg_y;
    mode_t              mode;
  } ctx_t;

  typedef struct packed {
    logic [RW-1:0] d;
    logic [RW-1:0] rem_x;
    logic [RW-1:0] rem_y;
    logic [QW-1:0] low_x;
    logic [QW-1:0] low_y;
    logic [QW-1:0] q_x;
    logic [QW-1:0] q_y;
    ctx_t          ctx;
  } div_t;

  typedef struct packed {
    logic [SW-1:0]      s;
    logic [SRW-1:0]     rem;
    logic [RTW-1:0]     root;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic               degen;
  } sq_t;

endpackage

[sv/cpos_if.sv]
// ----------------------------------------------------------------------------
// Closest point on segment: channel interfaces
// Query, result and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
interface cpos_query_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] ax;
  logic signed [31:0] ay;
  logic signed [31:0] bx;
  logic signed [31:0] by_coord;
  logic signed [31:0] px;
  logic signed [31:0] py;
  modport source (output valid, ax, ay, bx, by_coord, px, py, input ready);
  modport sink   (input valid, ax, ay, bx, by_coord, px, py, output ready);
endinterface

interface cpos_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] closest_x;
  logic signed [31:0] closest_y;
  logic [31:0]        distance;
  logic               on_edge;
  logic               degenerate;
  modport source (output valid, closest_x, closest_y, distance, on_edge, degenerate,
                  input ready);
  modport sink   (input valid, closest_x, closest_y, distance, on_edge, degenerate,
                  output ready);
endinterface

interface cpos_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[sv/cpos_div_cell.sv]
// ----------------------------------------------------------------------------
// Closest point on segment: divider cell
// One restoring quotient bit for both axes against a shared divisor.
// ----------------------------------------------------------------------------
module cpos_div_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  cpos_pkg::div_t in_data,
  output logic          out_valid,
  output cpos_pkg::div_t out_data
);
  import cpos_pkg::*;

  function automatic logic [RW:0] div_step(input logic [RW-1:0] rem,
                                           input logic          din,
                                           input logic [RW-1:0] d);
    logic [RW:0] t;
    logic [RW:0] res;
    t = {rem, din};
    if (t >= {1'b0, d}) begin
      res = {1'b1, RW'(t - {1'b0, d})};
    end else begin
      res = {1'b0, t[RW-1:0]};
    end
    return res;
  endfunction

  div_t        nxt;
  logic [RW:0] sx;
  logic [RW:0] sy;

  always_comb begin
    sx = div_step(in_data.rem_x, in_data.low_x[QW-1], in_data.d);
    sy = div_step(in_data.rem_y, in_data.low_y[QW-1], in_data.d);
    nxt = in_data;
    nxt.rem_x = sx[RW-1:0];
    nxt.rem_y = sy[RW-1:0];
    nxt.q_x   = {in_data.q_x[QW-2:0], sx[RW]};
    nxt.q_y   = {in_data.q_y[QW-2:0], sy[RW]};
    nxt.low_x = {in_data.low_x[QW-2:0], 1'b0};
    nxt.low_y = {in_data.low_y[QW-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= nxt;
    end
  end
endmodule

[sv/cpos_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// Closest point on segment: square root cell
// One digit-by-digit root bit from the next two radicand bits.
// ----------------------------------------------------------------------------
module cpos_sqrt_cell (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         in_valid,
  input  cpos_pkg::sq_t in_data,
  output logic         out_valid,
  output cpos_pkg::sq_t out_data
);
  import cpos_pkg::*;

  sq_t            nxt;
  logic [SRW-1:0] t;
  logic [SRW-1:0] trial;

  always_comb begin
    t     = {in_data.rem[SRW-3:0], in_data.s[SW-1:SW-2]};
    trial = SRW'({in_data.root, 2'b01});
    nxt   = in_data;
    nxt.s = {in_data.s[SW-3:0], 2'b00};
    if (t >= trial) begin
      nxt.rem  = t - trial;
      nxt.root = {in_data.root[RTW-2:0], 1'b1};
    end else begin
      nxt.rem  = t;
      nxt.root = {in_data.root[RTW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= nxt;
    end
  end
endmodule

[sv/closest_point_on_segment_unit.sv]
// Throughput: one word per cycle; the whole pipe holds while the result
// register is full and not taken. Depth is set by the 32-cell divider row
// and the 34-cell square root row. Synchronous reset clears all valid bits
// and loads the tolerance with round(0.001 * 2^FRAC_BITS).
// ----------------------------------------------------------------------------
// Closest point on segment: top level
// Projection, clamp, per-axis rounded divide and distance via cell rows.
// ----------------------------------------------------------------------------
module closest_point_on_segment_unit #(
  parameter int FRAC_BITS = 16
) (
  input logic           clk,
  input logic           rst,
  cpos_query_if.sink    query,
  cpos_result_if.source result,
  cpos_cfg_if.sink      cfg
);
  import cpos_pkg::*;

  localparam logic [31:0] TOL_RST = 32'(((1 << FRAC_BITS) + 500) / 1000);

  logic        adv;
  logic [31:0] tol;

  assign adv         = !result.valid || result.ready;
  assign query.ready = adv;
  assign cfg.ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_RST;
    end else if (cfg.valid) begin
      tol <= cfg.data;
    end
  end

  // stage 0: differences
  logic               v0;
  logic signed [32:0] dx0, dy0, apx0, apy0;
  ctx_t               c0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= query.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx0         <= 33'(query.bx) - 33'(query.ax);
      dy0         <= 33'(query.by_coord) - 33'(query.ay);
      apx0        <= 33'(query.px) - 33'(query.ax);
      apy0        <= 33'(query.py) - 33'(query.ay);
      c0.ax       <= query.ax;
      c0.ay       <= query.ay;
      c0.bx       <= query.bx;
      c0.by_coord <= query.by_coord;
      c0.px       <= query.px;
      c0.py       <= query.py;
      c0.neg_x    <= query.bx < query.ax;
      c0.neg_y    <= query.by_coord < query.ay;
      c0.mode     <= MODE_A;
    end
  end

  // stage 1: products
  logic               v1, deg1;
  logic signed [65:0] dxx1, dyy1, nx1, ny1;
  logic [31:0]        magx1, magy1;
  ctx_t               c1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dxx1  <= dx0 * dx0;
      dyy1  <= dy0 * dy0;
      nx1   <= apx0 * dx0;
      ny1   <= apy0 * dy0;
      magx1 <= dx0[32] ? 32'(-dx0) : dx0[31:0];
      magy1 <= dy0[32] ? 32'(-dy0) : dy0[31:0];
      deg1  <= (dx0 == '0) && (dy0 == '0);
      c1    <= c0;
    end
  end

  // stage 2: dot products and clamp decision
  logic               v2;
  logic [64:0]        den2;
  logic [64:0]        num2;
  logic [31:0]        magx2, magy2;
  ctx_t               c2;
  ctx_t               c2_next;
  logic [65:0]        dsum;
  logic signed [66:0] nsum;
  mode_t              mode_c;

  always_comb begin
    dsum = $unsigned(dxx1) + $unsigned(dyy1);
    nsum = 67'(nx1) + 67'(ny1);
    if (deg1) begin
      mode_c = MODE_DEGEN;
    end else if (nsum[66] || nsum == '0) begin
      mode_c = MODE_A;
    end else if ($unsigned(nsum) >= {1'b0, dsum}) begin
      mode_c = MODE_B;
    end else begin
      mode_c = MODE_MID;
    end
    c2_next      = c1;
    c2_next.mode = mode_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      den2    <= dsum[64:0];
      num2    <= nsum[64:0];
      magx2   <= magx1;
      magy2   <= magy1;
      c2      <= c2_next;
    end
  end

  // stage 3: partial products |d| * num, 22-bit slices
  logic        v3;
  logic [53:0] ppx3 [3];
  logic [53:0] ppy3 [3];
  logic [64:0] den3;
  ctx_t        c3;
  logic [65:0] nu;

  assign nu = {1'b0, num2};

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        ppx3[k] <= magx2 * nu[22*k +: 22];
        ppy3[k] <= magy2 * nu[22*k +: 22];
      end
      den3 <= den2;
      c3   <= c2;
    end
  end

  // stage 4: sum of partial products
  logic        v4;
  logic [96:0] accx4, accy4;
  logic [64:0] den4;
  ctx_t        c4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      accx4 <= 97'(ppx3[0]) + (97'(ppx3[1]) << 22) + (97'(ppx3[2]) << 44);
      accy4 <= 97'(ppy3[0]) + (97'(ppy3[1]) << 22) + (97'(ppy3[2]) << 44);
      den4  <= den3;
      c4    <= c3;
    end
  end

  // stage 5: rounded dividend 2*|d|*num + den, divisor 2*den
  logic        dv [QW+1];
  div_t        dd [QW+1];
  logic [97:0] nx5, ny5;

  assign nx5 = {accx4, 1'b0} + 98'(den4);
  assign ny5 = {accy4, 1'b0} + 98'(den4);

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (adv) begin
      dv[0] <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dd[0].d     <= {den4, 1'b0};
      dd[0].rem_x <= nx5[97:QW];
      dd[0].rem_y <= ny5[97:QW];
      dd[0].low_x <= nx5[QW-1:0];
      dd[0].low_y <= ny5[QW-1:0];
      dd[0].q_x   <= '0;
      dd[0].q_y   <= '0;
      dd[0].ctx   <= c4;
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_div
    cpos_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .in_valid  (dv[i]),
      .in_data   (dd[i]),
      .out_valid (dv[i+1]),
      .out_data  (dd[i+1])
    );
  end

  // closest point
  logic               vc, degc;
  logic signed [31:0] cxc, cyc, pxc, pyc;
  ctx_t               cq;
  logic signed [32:0] offx, offy;

  assign cq   = dd[QW].ctx;
  assign offx = cq.neg_x ? -33'(dd[QW].q_x) : 33'(dd[QW].q_x);
  assign offy = cq.neg_y ? -33'(dd[QW].q_y) : 33'(dd[QW].q_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (adv) begin
      vc <= dv[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      unique case (cq.mode)
        MODE_DEGEN: begin
          cxc <= '0;
          cyc <= '0;
        end
        MODE_A: begin
          cxc <= cq.ax;
          cyc <= cq.ay;
        end
        MODE_B: begin
          cxc <= cq.bx;
          cyc <= cq.by_coord;
        end
        default: begin
          cxc <= 32'(33'(cq.ax) + offx);
          cyc <= 32'(33'(cq.ay) + offy);
        end
      endcase
      pxc  <= cq.px;
      pyc  <= cq.py;
      degc <= cq.mode == MODE_DEGEN;
    end
  end

  // residual
  logic               vr, degr;
  logic signed [32:0] rxr, ryr;
  logic signed [31:0] cxr, cyr;

  always_ff @(posedge clk) begin
    if (rst) begin
      vr <= 1'b0;
    end else if (adv) begin
      vr <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rxr  <= 33'(pxc) - 33'(cxc);
      ryr  <= 33'(pyc) - 33'(cyc);
      cxr  <= cxc;
      cyr  <= cyc;
      degr <= degc;
    end
  end

  // squares
  logic               vm, degm;
  logic signed [65:0] rxxm, ryym;
  logic signed [31:0] cxm, cym;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (adv) begin
      vm <= vr;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rxxm <= rxr * rxr;
      ryym <= ryr * ryr;
      cxm  <= cxr;
      cym  <= cyr;
      degm <= degr;
    end
  end

  // radicand into the root row
  logic sv [RTW+1];
  sq_t  sd [RTW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (adv) begin
      sv[0] <= vm;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd[0].s     <= SW'($unsigned(rxxm)) + SW'($unsigned(ryym));
      sd[0].rem   <= '0;
      sd[0].root  <= '0;
      sd[0].cx    <= cxm;
      sd[0].cy    <= cym;
      sd[0].degen <= degm;
    end
  end

  for (genvar j = 0; j < RTW; j++) begin : g_sqrt
    cpos_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .in_valid  (sv[j]),
      .in_data   (sd[j]),
      .out_valid (sv[j+1]),
      .out_data  (sd[j+1])
    );
  end

  // result register
  logic               ov, oedge, odeg;
  logic signed [31:0] ocx, ocy;
  logic [31:0]        odist, dist_c;

  assign dist_c = (sd[RTW].root[RTW-1:32] != '0) ? '1 : sd[RTW].root[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (adv) begin
      ov <= sv[RTW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      odeg <= sd[RTW].degen;
      if (sd[RTW].degen) begin
        ocx   <= '0;
        ocy   <= '0;
        odist <= '0;
        oedge <= 1'b0;
      end else begin
        ocx   <= sd[RTW].cx;
        ocy   <= sd[RTW].cy;
        odist <= dist_c;
        oedge <= dist_c < tol;
      end
    end
  end

  assign result.valid      = ov;
  assign result.closest_x  = ocx;
  assign result.closest_y  = ocy;
  assign result.distance   = odist;
  assign result.on_edge    = oedge;
  assign result.degenerate = odeg;
endmodule

[sv/cpos_checker.sv]
// ----------------------------------------------------------------------------
// Closest point on segment: port checker
// Watches the top-level channels and is bound to the top level.
// ----------------------------------------------------------------------------
`include "closest_point_on_segment_unit_defines.svh"

module cpos_checker (
  input logic        clk,
  input logic        rst,
  input logic        query_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic [31:0] closest_x,
  input logic [31:0] closest_y,
  input logic [31:0] distance,
  input logic        on_edge,
  input logic        degenerate
);
  `CPOS_ASSERT(a_hold, result_valid && !result_ready |=> result_valid && $stable(closest_x) && $stable(closest_y) && $stable(distance) && $stable(on_edge) && $stable(degenerate), "result word changed while stalled")
  `CPOS_ASSERT(a_degen, result_valid && degenerate |-> closest_x == '0 && closest_y == '0 && distance == '0 && !on_edge, "degenerate word not zeroed")
  `CPOS_ASSERT(a_edge, result_valid && on_edge |-> distance != 32'hFFFF_FFFF, "on_edge with saturated distance")
  `CPOS_ASSERT_ALWAYS(a_ready, !result_valid |-> query_ready, "query stalled with empty result")
endmodule

bind closest_point_on_segment_unit cpos_checker u_cpos_checker (
  .clk          (clk),
  .rst          (rst),
  .query_ready  (query.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .closest_x    (result.closest_x),
  .closest_y    (result.closest_y),
  .distance     (result.distance),
  .on_edge      (result.on_edge),
  .degenerate   (result.degenerate)
);

[bench/closest_point_on_segment_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Closest point on segment: testbench
// Drives segment/point queries through the valid/ready channels, predicts
// the clamped projection, distance and flags per query in wide integer
// arithmetic, and checks every result word in order. Runs several tolerance
// settings and idle/stall mixes, including a long output hold.
// ----------------------------------------------------------------------------
module closest_point_on_segment_unit_tb;

  typedef struct {
    logic signed [31:0] ax, ay, bx, by_coord, px, py;
  } seg_query_t;

  typedef struct {
    logic signed [31:0] closest_x, closest_y;
    logic [31:0]        distance;
    logic               on_edge, degenerate;
  } seg_result_t;

  typedef struct {
    seg_query_t  q;
    bit          known;
    seg_result_t r;
  } directed_row_t;

  localparam logic signed [31:0] SMIN = 32'sh8000_0000;
  localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] ONE  = 32'sh0001_0000;

  logic clk;
  logic rst;

  cpos_query_if  query ();
  cpos_result_if result ();
  cpos_cfg_if    cfg ();

  closest_point_on_segment_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .query  (query),
    .result (result),
    .cfg    (cfg)
  );

  logic [31:0]  tolerance;
  seg_result_t  pending_q[$];
  int           src_idle_pct;
  int           snk_stall_pct;
  bit           hold_req;
  int           mismatches;
  int           results_seen;
  int           queries_sent;
  int           on_edge_seen;
  int           degen_seen;
  int           sat_seen;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("closest_point_on_segment_unit verification failed");
    $finish;
  end

  function automatic seg_result_t project_point(seg_query_t q);
    logic signed [127:0] ax, ay, bx, by, px, py, dx, dy, num, den;
    logic signed [127:0] cx, cy, rx, ry, s, root, c, mag, m;
    seg_result_t res;
    ax = q.ax; ay = q.ay; bx = q.bx; by = q.by_coord; px = q.px; py = q.py;
    dx = bx - ax;
    dy = by - ay;
    res = '{closest_x: '0, closest_y: '0, distance: '0, on_edge: 1'b0, degenerate: 1'b0};
    if (dx == 0 && dy == 0) begin
      res.degenerate = 1'b1;
      return res;
    end
    den = dx * dx + dy * dy;
    num = (px - ax) * dx + (py - ay) * dy;
    if (num <= 0) begin
      cx = ax; cy = ay;
    end else if (num >= den) begin
      cx = bx; cy = by;
    end else begin
      mag = (dx < 0) ? -dx : dx;
      m = (2 * num * mag + den) / (2 * den);
      cx = ax + ((dx < 0) ? -m : m);
      mag = (dy < 0) ? -dy : dy;
      m = (2 * num * mag + den) / (2 * den);
      cy = ay + ((dy < 0) ? -m : m);
    end
    rx = px - cx;
    ry = py - cy;
    s = rx * rx + ry * ry;
    root = 0;
    for (int b = 33; b >= 0; b--) begin
      c = root | (128'sd1 << b);
      if (c * c <= s) root = c;
    end
    if (root > 128'sh0_FFFF_FFFF) root = 128'sh0_FFFF_FFFF;
    res.closest_x = cx[31:0];
    res.closest_y = cy[31:0];
    res.distance  = root[31:0];
    res.on_edge   = (root[31:0] < tolerance);
    return res;
  endfunction

  // expected word at query acceptance
  always @(posedge clk) begin
    if (!rst && query.valid && query.ready) begin
      seg_query_t q;
      q = '{query.ax, query.ay, query.bx, query.by_coord, query.px, query.py};
      pending_q.push_back(project_point(q));
    end
    if (!rst && cfg.valid && cfg.ready) tolerance <= cfg.data;
  end

  // result checking
  always @(posedge clk) begin
    if (!rst && result.valid && result.ready) begin
      seg_result_t e;
      results_seen++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result word with nothing pending");
      end else begin
        e = pending_q.pop_front();
        if (result.closest_x !== e.closest_x || result.closest_y !== e.closest_y ||
            result.distance !== e.distance || result.on_edge !== e.on_edge ||
            result.degenerate !== e.degenerate) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp x=%h y=%h d=%h oe=%b dg=%b  got x=%h y=%h d=%h oe=%b dg=%b",
                     e.closest_x, e.closest_y, e.distance, e.on_edge, e.degenerate,
                     result.closest_x, result.closest_y, result.distance,
                     result.on_edge, result.degenerate);
        end
        on_edge_seen += e.on_edge;
        degen_seen   += e.degenerate;
        sat_seen     += (e.distance == 32'hFFFF_FFFF);
      end
    end
  end

  // receiver: random stalls plus an occasional long hold
  initial begin
    int hold_left;
    hold_left = 0;
    result.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && hold_left == 0) begin
        hold_left = 600;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result.ready <= 1'b0;
      end else begin
        result.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  task automatic send_query(seg_query_t q);
    while ($urandom_range(99) < src_idle_pct) begin
      query.valid <= 1'b0;
      @(posedge clk);
    end
    query.valid    <= 1'b1;
    query.ax       <= q.ax;
    query.ay       <= q.ay;
    query.bx       <= q.bx;
    query.by_coord <= q.by_coord;
    query.px       <= q.px;
    query.py       <= q.py;
    do @(posedge clk); while (!query.ready);
    queries_sent++;
  endtask

  task automatic drain();
    query.valid <= 1'b0;
    @(posedge clk);
    wait (pending_q.size() == 0);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [31:0] value);
    cfg.valid <= 1'b1;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord(int kind);
    case (kind)
      0:       return $urandom();
      1:       return $signed($urandom_range(2 * 65536 * 20)) - 65536 * 20;
      default: return $signed($urandom_range(400)) - 200;
    endcase
  endfunction

  function automatic seg_query_t rand_query();
    seg_query_t q;
    int kind, shape;
    kind  = $urandom_range(9) < 2 ? 0 : ($urandom_range(3) == 0 ? 2 : 1);
    shape = $urandom_range(9);
    q.ax = rand_coord(kind);
    q.ay = rand_coord(kind);
    q.bx = rand_coord(kind);
    q.by_coord = rand_coord(kind);
    q.px = rand_coord(kind);
    q.py = rand_coord(kind);
    if (shape == 0) begin
      q.bx = q.ax;
      q.by_coord = q.ay;
    end else if (shape < 4) begin
      // query near or on the segment
      q.px = q.ax + (q.bx - q.ax) / 2 + $signed($urandom_range(160)) - 80;
      q.py = q.ay + (q.by_coord - q.ay) / 2 + $signed($urandom_range(160)) - 80;
    end
    return q;
  endfunction

  directed_row_t dir_rows[$];
  logic [31:0]   tol_set[5];

  initial begin
    seg_result_t z;
    z = '{closest_x: '0, closest_y: '0, distance: '0, on_edge: 1'b0, degenerate: 1'b0};
    rst = 1'b1;
    query.valid = 1'b0;
    query.ax = '0; query.ay = '0; query.bx = '0;
    query.by_coord = '0; query.px = '0; query.py = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    tolerance = 32'd66;
    hold_req = 1'b0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    mismatches = 0;
    results_seen = 0;
    queries_sent = 0;
    on_edge_seen = 0;
    degen_seen = 0;
    sat_seen = 0;

    dir_rows.push_back('{'{0, 0, 0, 0, 5, 7}, 1,
                        '{0, 0, 0, 1'b0, 1'b1}});
    dir_rows.push_back('{'{SMIN, SMAX, SMIN, SMAX, SMAX, SMIN}, 1,
                        '{0, 0, 0, 1'b0, 1'b1}});
    dir_rows.push_back('{'{0, 0, ONE, 0, 0, 0}, 1,
                        '{0, 0, 0, 1'b1, 1'b0}});
    dir_rows.push_back('{'{0, 0, ONE, 0, 2 * ONE, 0}, 1,
                        '{ONE, 0, 32'd65536, 1'b0, 1'b0}});
    dir_rows.push_back('{'{0, 0, ONE, 0, -ONE, 0}, 1,
                        '{0, 0, 32'd65536, 1'b0, 1'b0}});
    dir_rows.push_back('{'{SMIN, SMIN, SMIN, SMIN + 1, SMAX, SMAX}, 1,
                        '{SMIN, SMIN + 1, 32'hFFFF_FFFF, 1'b0, 1'b0}});
    dir_rows.push_back('{'{0, 0, ONE, ONE, ONE / 2, 0}, 0, z});
    dir_rows.push_back('{'{SMIN, SMIN, SMAX, SMAX, SMIN, SMAX}, 0, z});
    dir_rows.push_back('{'{SMAX, SMIN, SMIN, SMAX, 0, 0}, 0, z});
    dir_rows.push_back('{'{SMIN, 0, SMAX, 0, 3, 65}, 0, z});
    dir_rows.push_back('{'{SMIN, 0, SMAX, 0, 3, 66}, 0, z});
    dir_rows.push_back('{'{-3, -3, 3, 3, 1, 0}, 0, z});
    dir_rows.push_back('{'{0, 0, 3, 0, 1, 5}, 0, z});
    dir_rows.push_back('{'{0, 0, -3, 0, -2, -5}, 0, z});
    dir_rows.push_back('{'{SMAX, SMAX, SMAX - 1, SMAX, SMIN, SMIN}, 0, z});

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at reset tolerance
    foreach (dir_rows[i]) begin
      if (dir_rows[i].known && project_point(dir_rows[i].q) != dir_rows[i].r) begin
        mismatches++;
        if (mismatches <= 10) $display("directed row %0d: predictor disagrees with table", i);
      end
      send_query(dir_rows[i].q);
    end
    drain();

    tol_set = '{32'd66, 32'd0, 32'hFFFF_FFFF, $urandom(), 32'd65536};
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) write_tolerance(tol_set[ph]);
      case (ph % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 47; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 47; end
        default: begin src_idle_pct = 10; snk_stall_pct = 10; end
      endcase
      if (ph == 4) begin
        src_idle_pct = 0;
        snk_stall_pct = 0;
        hold_req = 1'b1;
      end
      for (int n = 0; n < 228; n++) begin
        if (ph == 3 && n == 114) drain();
        send_query(rand_query());
      end
      drain();
    end

    $display("ran %0d queries, %0d results: %0d on edge, %0d degenerate, %0d saturated",
             queries_sent, results_seen, on_edge_seen, degen_seen, sat_seen);
    $display("five tolerance settings (reset, zero, max, random, one), four idle mixes");
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("closest_point_on_segment_unit verification clean");
    end else begin
      $display("closest_point_on_segment_unit verification failed");
    end
    $finish;
  end

endmodule

[closest_point_on_segment_unit.f]
+incdir+sv
sv/cpos_pkg.sv
sv/cpos_if.sv
sv/cpos_div_cell.sv
sv/cpos_sqrt_cell.sv
sv/closest_point_on_segment_unit.sv
sv/cpos_checker.sv
bench/closest_point_on_segment_unit_tb.sv
